// ===== src/lzid_pkg.sv =====
// shared types and constants of the lzss image decoder
package lzid_pkg;

    localparam int unsigned RING_SIZE_DEF = 4096;

    localparam logic [7:0] CODE_INVERT = 8'hff;
    localparam logic [3:0] FLAG_ITEMS  = 4'd8;
    localparam logic [4:0] MATCH_MIN   = 5'd3;

    // configuration register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       start_image;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  pixel_value;
        logic [31:0] pixel_address;
        logic        run_last;
        logic        image_done;
    } t_out_item;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } t_state;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_BYTE,
        PH_LOWER
    } t_phase;

endpackage

// ===== src/lzss_image_decoder.sv =====
// lzss image decoder top level: byte parser, copy sequencer and pixel stage
//
// takes one stored byte per request (inverted on entry) and emits decoded
// pixels with their bottom-up raster address. flag bytes and the upper byte
// of a match give no pixel, and a literal gives one pixel. after the lower
// byte of a match, the copy reads the 4096-byte window ring once per cycle
// through its single read port while the pixel stage has room, for a match
// length L of 3 to 18; no new request is taken until the copy ends. pixels
// leave through an output register, so the next request can be taken while
// a pixel waits; output stalls stop the copy. a request with start_image set
// restarts the decoder and empties the ring at once (tracked by a fill
// count, no clearing pass). pixels past width*height are dropped while the
// ring keeps updating. the user must write width and height through the
// config port only while the block is idle; the block does not enforce it.
module lzss_image_decoder
    import lzid_pkg::*;
#(
    parameter int unsigned RING_SIZE = RING_SIZE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // config port
    input  logic      i_cfg_we,
    input  logic      i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // byte requests
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    // pixel results
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int unsigned AW = $clog2(RING_SIZE);

    // config registers and cached image size
    logic [15:0] r_width;
    logic [15:0] r_height;
    logic [31:0] r_size;

    // parser and copy sequencer
    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [7:0]    r_flags, n_flags;
    logic [3:0]    r_fcount, n_fcount;
    logic [7:0]    r_upper, n_upper;
    logic [AW-1:0] r_pos, n_pos;
    logic [4:0]    r_left, n_left;

    // pixel stage holding one decoded byte
    logic       r_w_valid, n_w_valid;
    logic       r_w_lit, n_w_lit;
    logic [7:0] r_w_lit_byte, n_w_lit_byte;
    logic       r_w_last, n_w_last;

    // pixel counters
    logic [31:0] r_pix_count;
    logic [15:0] r_col;
    logic [15:0] r_row;

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    logic          in_ready;
    logic          accept;
    logic          restart;
    logic [7:0]    b;
    t_phase        eff_phase;
    logic          issue_ok;
    logic          rd_en;
    logic          lit_issue;
    logic [7:0]    ring_data;
    logic [7:0]    w_byte;
    logic          drop;
    logic          w_fire;
    logic          emit;
    logic          done;
    logic [31:0]   pix_inc;
    logic [15:0]   col_inc;
    logic signed [16:0] flip;
    logic signed [33:0] prod;
    logic [31:0]   addr;
    logic [3:0]    fcount_dec;

    // ---------------- config ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 16'd1;
            r_height <= 16'd1;
            r_size   <= 32'd1;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    default:    r_width  <= r_width;
                endcase
            end
            // registered product, it follows the config registers in the next cycle; settles before any pixel
            r_size <= r_width * r_height;
        end
    end

    // ---------------- pixel stage ----------------
    assign w_byte   = r_w_lit ? r_w_lit_byte : ring_data;
    assign drop     = r_pix_count >= r_size;
    assign w_fire   = r_w_valid && (drop || !r_out_valid || i_out_ready);
    assign emit     = w_fire && !drop;
    assign issue_ok = !r_w_valid || w_fire;

    assign pix_inc = r_pix_count + 32'd1;
    assign done    = pix_inc == r_size;
    assign col_inc = r_col + 16'd1;

    // bottom-up raster address, wraps modulo 2^32
    assign flip = $signed({1'b0, r_height}) - 17'sd1 - $signed({1'b0, r_row});
    assign prod = $signed({1'b0, r_width}) * flip;
    assign addr = prod[31:0] + {16'd0, r_col};

    // ---------------- byte parser ----------------
    assign in_ready   = (r_state == ST_IDLE) && issue_ok;
    assign accept     = i_in_valid && in_ready;
    assign restart    = accept && i_in_data.start_image;
    assign b          = i_in_data.code_byte ^ CODE_INVERT;
    assign eff_phase  = i_in_data.start_image ? PH_FLAG : r_phase;
    assign fcount_dec = (r_fcount != 4'd0) ? r_fcount - 4'd1 : 4'd0;

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_flags      = r_flags;
        n_fcount     = r_fcount;
        n_upper      = r_upper;
        n_pos        = r_pos;
        n_left       = r_left;
        n_w_valid    = r_w_valid && !w_fire;
        n_w_lit      = r_w_lit;
        n_w_lit_byte = r_w_lit_byte;
        n_w_last     = r_w_last;
        rd_en        = 1'b0;
        lit_issue    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_data.start_image) begin
                        n_upper = 8'd0;
                    end
                    case (eff_phase)
                        PH_FLAG: begin
                            n_flags  = b;
                            n_fcount = FLAG_ITEMS;
                            n_phase  = PH_BYTE;
                        end
                        PH_BYTE: begin
                            if (r_flags[7]) begin
                                // literal goes straight to the pixel stage
                                lit_issue = 1'b1;
                                n_flags   = {r_flags[6:0], 1'b0};
                                n_fcount  = fcount_dec;
                                n_phase   = (fcount_dec == 4'd0) ? PH_FLAG : PH_BYTE;
                            end else begin
                                n_upper = b;
                                n_phase = PH_LOWER;
                            end
                        end
                        PH_LOWER: begin
                            // position: upper high nibble, lower byte above it
                            n_pos    = AW'({b, r_upper[7:4]});
                            n_left   = {1'b0, r_upper[3:0]} + MATCH_MIN;
                            n_state  = ST_COPY;
                            n_flags  = {r_flags[6:0], 1'b0};
                            n_fcount = fcount_dec;
                            n_phase  = (fcount_dec == 4'd0) ? PH_FLAG : PH_BYTE;
                        end
                        default: begin
                            n_phase = PH_FLAG;
                        end
                    endcase
                end
            end
            ST_COPY: begin
                // one ring read per cycle while the pixel stage has room
                if (issue_ok) begin
                    rd_en  = 1'b1;
                    n_pos  = r_pos + AW'(1);
                    n_left = r_left - 5'd1;
                    if (r_left == 5'd1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (rd_en || lit_issue) begin
            n_w_valid    = 1'b1;
            n_w_lit      = lit_issue;
            n_w_lit_byte = b;
            n_w_last     = lit_issue || (r_left == 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_FLAG;
            r_flags   <= 8'd0;
            r_fcount  <= 4'd0;
            r_upper   <= 8'd0;
            r_pos     <= '0;
            r_left    <= 5'd0;
            r_w_valid <= 1'b0;
            r_w_lit   <= 1'b0;
            r_w_last  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_flags   <= n_flags;
            r_fcount  <= n_fcount;
            r_upper   <= n_upper;
            r_pos     <= n_pos;
            r_left    <= n_left;
            r_w_valid <= n_w_valid;
            r_w_lit   <= n_w_lit;
            r_w_last  <= n_w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_lit_byte <= n_w_lit_byte;
    end

    // ---------------- counters ----------------
    // a restart comes only with a request, when the pixel stage is empty or its pixel leaves in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_count <= 32'd0;
            r_col       <= 16'd0;
            r_row       <= 16'd0;
        end else if (restart) begin
            r_pix_count <= 32'd0;
            r_col       <= 16'd0;
            r_row       <= 16'd0;
        end else if (emit) begin
            r_pix_count <= pix_inc;
            if (col_inc >= r_width) begin
                r_col <= 16'd0;
                r_row <= r_row + 16'd1;
            end else begin
                r_col <= col_inc;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.pixel_value   <= w_byte;
            r_out.pixel_address <= addr;
            // the image end also ends the pixels of this request
            r_out.run_last      <= r_w_last || done;
            r_out.image_done    <= done;
        end
    end

    // ---------------- window ring ----------------
    lzid_ring #(
        .RING_SIZE (RING_SIZE)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_pos),
        .i_wr_en   (w_fire),
        .i_wr_data (w_byte),
        .o_rd_data (ring_data)
    );

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/lzid_ring.sv =====
// window ring memory with fill tracking and same-cycle write forwarding
module lzid_ring
    import lzid_pkg::*;
#(
    parameter int unsigned RING_SIZE = RING_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_restart,
    input  logic                         i_rd_en,
    input  logic [$clog2(RING_SIZE)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [7:0]                   i_wr_data,
    output logic [7:0]                   o_rd_data
);

    localparam int unsigned AW       = $clog2(RING_SIZE);
    localparam int unsigned WP_START = RING_SIZE - 18;

    logic [7:0]    mem [RING_SIZE];
    logic [7:0]    r_q;
    logic [7:0]    r_fwd_data;
    logic          r_fwd;
    logic          r_zero;
    logic [AW-1:0] r_wp;
    logic [AW:0]   r_fill;

    logic [AW-1:0] rel;
    logic          hit;
    logic          filled;

    // entries are written in order from the start pointer, so the fill count
    // tells which ones hold data since the last restart
    assign rel    = i_rd_addr - AW'(WP_START);
    assign filled = {1'b0, rel} < r_fill;
    assign hit    = i_wr_en && (i_rd_addr == r_wp);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[r_wp] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_q <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd  <= 1'b0;
            r_zero <= 1'b1;
            r_wp   <= AW'(WP_START);
            r_fill <= '0;
        end else begin
            if (i_rd_en) begin
                r_fwd  <= hit;
                r_zero <= !hit && !filled;
            end
            if (i_restart) begin
                r_wp   <= AW'(WP_START);
                r_fill <= '0;
            end else if (i_wr_en) begin
                r_wp <= r_wp + AW'(1);
                if (r_fill != (AW+1)'(RING_SIZE)) begin
                    r_fill <= r_fill + (AW+1)'(1);
                end
            end
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : (r_zero ? 8'h00 : r_q);

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the lzss image decoder
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzid_pkg::*;

    // run shape
    localparam int DIR_ROWS    = 21;
    localparam int RAND_PHASES = 10;
    localparam int PHASE_ITEMS = 45;
    // settle time covers the longest match copy (18 bytes) plus the output register
    localparam int SETTLE      = 32;
    localparam int DRAIN_MAX   = 50000;
    localparam int CYCLE_LIMIT = 2000000;

    // directed rows: a request, or a new image size written while idle
    typedef enum logic {
        ROW_REQ,
        ROW_SIZE
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        typed;   // pixel below is the whole expectation
        logic        has_px;
        t_in_item    req;
        t_out_item   px;
        logic [15:0] w;
        logic [15:0] h;
    } t_row;

    // dut hookup
    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    t_in_item    in_data;
    logic        out_valid;
    logic        out_ready;
    t_out_item   out_data;

    lzss_image_decoder uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // 4 ns clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // decoder mirror: window, parser state, raster counters, image size
    logic [7:0]  window_mem [RING_SIZE_DEF];
    logic [11:0] wr_ptr;
    logic [7:0]  flag_reg;
    logic [3:0]  flags_left;
    logic [7:0]  upper_reg;
    t_phase      dec_phase;
    logic [31:0] pix_count;
    logic [15:0] col_cnt;
    logic [15:0] row_cnt;
    logic [15:0] img_w;
    logic [15:0] img_h;

    t_out_item   byte_pixels [$];   // pixels of the request being decoded
    t_out_item   pixels_due [$];    // pixels still owed by the block
    logic [7:0]  lower_plan;        // lower byte of the match being built
    logic        no_idle;
    int          fail_count;
    int          cycle_cnt;
    t_row        dir_rows [DIR_ROWS];

    function automatic void restart_decoder();
        for (int i = 0; i < RING_SIZE_DEF; i++) begin
            window_mem[i] = 8'h00;
        end
        wr_ptr     = 12'hfee;
        flag_reg   = 8'h00;
        flags_left = 4'd0;
        upper_reg  = 8'h00;
        dec_phase  = PH_FLAG;
        pix_count  = 32'd0;
        col_cnt    = 16'd0;
        row_cnt    = 16'd0;
    endfunction

    function automatic logic [31:0] image_area();
        return {16'd0, img_w} * {16'd0, img_h};
    endfunction

    // every decoded byte lands in the window; only pixels inside the image come out
    function automatic void put_pixel(input logic [7:0] v);
        logic [31:0] area;
        logic [31:0] flip;
        t_out_item   px;
        area = image_area();
        window_mem[wr_ptr] = v;
        wr_ptr = wr_ptr + 12'd1;
        if (pix_count < area) begin
            // bottom-up raster: row 0 is the last line of the image
            flip = {16'd0, img_h} - 32'd1 - {16'd0, row_cnt};
            px.pixel_value   = v;
            px.pixel_address = {16'd0, col_cnt} + {16'd0, img_w} * flip;
            pix_count        = pix_count + 32'd1;
            px.run_last      = 1'b0;
            px.image_done    = (pix_count == area);
            byte_pixels.push_back(px);
            col_cnt = col_cnt + 16'd1;
            if (col_cnt >= img_w) begin
                col_cnt = 16'd0;
                row_cnt = row_cnt + 16'd1;
            end
        end
    endfunction

    function automatic void next_flag_item();
        flag_reg = flag_reg << 1;
        if (flags_left != 4'd0) begin
            flags_left = flags_left - 4'd1;
        end
        dec_phase = (flags_left == 4'd0) ? PH_FLAG : PH_BYTE;
    endfunction

    // pixels that one stored byte yields, left in byte_pixels
    task automatic decode_byte(input t_in_item rq);
        logic [7:0]  b;
        logic [11:0] src;
        int          run_len;
        t_out_item   tail;
        b = rq.code_byte ^ CODE_INVERT;
        byte_pixels.delete();
        if (rq.start_image) begin
            restart_decoder();
        end
        case (dec_phase)
            PH_FLAG: begin
                flag_reg   = b;
                flags_left = FLAG_ITEMS;
                dec_phase  = PH_BYTE;
            end
            PH_BYTE: begin
                if (flag_reg[7]) begin
                    put_pixel(b);
                    next_flag_item();
                end else begin
                    upper_reg = b;
                    dec_phase = PH_LOWER;
                end
            end
            default: begin
                // byte-wise copy, so a source just behind the write pointer repeats
                run_len = int'(upper_reg[3:0]) + int'(MATCH_MIN);
                src     = {b, upper_reg[7:4]};
                for (int k = 0; k < run_len; k++) begin
                    put_pixel(window_mem[src]);
                    src = src + 12'd1;
                end
                next_flag_item();
            end
        endcase
        if (byte_pixels.size() != 0) begin
            tail = byte_pixels.pop_back();
            tail.run_last = 1'b1;
            byte_pixels.push_back(tail);
        end
    endtask

    // gaps: mostly none, some short, a few long; none at all in quiet phases
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // called at a clock edge; returns at the edge where the request is taken
    task automatic send_request(input t_in_item rq);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= rq;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
    endtask

    // predict, queue the expectation, then hand the request over
    task automatic issue(input t_in_item rq, input logic typed, input logic has_px,
                         input t_out_item px);
        decode_byte(rq);
        if (typed) begin
            if (has_px) begin
                pixels_due.push_back(px);
            end
        end else begin
            while (byte_pixels.size() != 0) begin
                pixels_due.push_back(byte_pixels.pop_front());
            end
        end
        send_request(rq);
    endtask

    // hold off requests until every owed pixel is out and dropped copies are done
    task automatic quiesce();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pixels_due.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_size(input logic [15:0] w, input logic [15:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        img_w = w;
        img_h = h;
    endtask

    // next stored byte: mostly a well-formed stream following the mirror's parser,
    // with some noise and stray restarts
    function automatic t_in_item next_request(input logic first);
        t_in_item    rq;
        logic [11:0] src;
        logic [3:0]  lenm;
        logic [7:0]  b;
        rq.start_image = 1'b0;
        if ($urandom_range(0, 99) < 4) begin
            rq.code_byte   = 8'($urandom);
            rq.start_image = ($urandom_range(0, 3) == 0);
            return rq;
        end
        // new image at the start of a phase, or often once the current one is full
        if (first || (dec_phase == PH_FLAG && pix_count >= image_area()
                      && $urandom_range(0, 9) < 7)) begin
            rq.start_image = 1'b1;
        end
        if (rq.start_image || dec_phase == PH_FLAG) begin
            case ($urandom_range(0, 3))
                0:       b = 8'hff;        // eight literals
                1:       b = 8'h00;        // eight matches
                default: b = 8'($urandom);
            endcase
        end else if (dec_phase == PH_BYTE && flag_reg[7]) begin
            b = 8'($urandom);
        end else if (dec_phase == PH_BYTE) begin
            // mostly copy from recent output, overlapping runs included
            if ($urandom_range(0, 9) < 7) begin
                src = wr_ptr - 12'($urandom_range(1, 40));
            end else begin
                src = 12'($urandom);
            end
            lenm       = 4'($urandom);
            b          = {src[3:0], lenm};
            lower_plan = src[11:4];
        end else begin
            b = lower_plan;
        end
        rq.code_byte = b ^ CODE_INVERT;
        return rq;
    endfunction

    function automatic t_row req_row(input logic [7:0] code, input logic st);
        t_row r;
        r = '0;
        r.kind            = ROW_REQ;
        r.req.code_byte   = code;
        r.req.start_image = st;
        return r;
    endfunction

    function automatic t_row seen_row(input logic [7:0] code, input logic st,
                                      input logic has_px, input logic [7:0] val,
                                      input logic [31:0] addr, input logic last,
                                      input logic done);
        t_row r;
        r = req_row(code, st);
        r.typed            = 1'b1;
        r.has_px           = has_px;
        r.px.pixel_value   = val;
        r.px.pixel_address = addr;
        r.px.run_last      = last;
        r.px.image_done    = done;
        return r;
    endfunction

    function automatic t_row size_row(input logic [15:0] w, input logic [15:0] h);
        t_row r;
        r = '0;
        r.kind = ROW_SIZE;
        r.w    = w;
        r.h    = h;
        return r;
    endfunction

    // receiver: random stalls on the pixel side
    initial begin
        int hold;
        out_ready = 1'b0;
        @(posedge clk);
        forever begin
            hold = idle_len();
            if (hold > 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // pixel checker: each taken pixel against the oldest expectation
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pixels_due.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected pixel: value %02h addr %08h last %b done %b",
                             out_data.pixel_value, out_data.pixel_address,
                             out_data.run_last, out_data.image_done);
                end
                fail_count++;
            end else begin
                want = pixels_due.pop_front();
                if (out_data.pixel_value !== want.pixel_value
                    || out_data.pixel_address !== want.pixel_address
                    || out_data.run_last !== want.run_last
                    || out_data.image_done !== want.image_done) begin
                    if (fail_count < 10) begin
                        $display("pixel mismatch: expected %02h %08h %b %b, got %02h %08h %b %b",
                                 want.pixel_value, want.pixel_address, want.run_last,
                                 want.image_done, out_data.pixel_value,
                                 out_data.pixel_address, out_data.run_last,
                                 out_data.image_done);
                    end
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int          p;
        int          k;
        logic        keep_image;
        logic [15:0] w;
        logic [15:0] h;
        t_in_item    rq;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_WIDTH;
        cfg_data   = 16'd0;
        in_valid   = 1'b0;
        in_data    = '0;
        no_idle    = 1'b0;
        fail_count = 0;
        cycle_cnt  = 0;
        lower_plan = 8'h00;
        restart_decoder();
        img_w = 16'd1;
        img_h = 16'd1;

        // directed rows; codes are stored inverted, comments give the decoded byte
        dir_rows = '{
            // 1x1 image after reset: flag 0xc0, two literals then matches
            seen_row(8'h3f, 1'b1, 1'b0, 8'h00, 32'd0, 1'b0, 1'b0),
            // literal 0xff is the only pixel of the image
            seen_row(8'h00, 1'b0, 1'b1, 8'hff, 32'd0, 1'b1, 1'b1),
            // literal 0x00 is past the image: ring only
            seen_row(8'hff, 1'b0, 1'b0, 8'h00, 32'd0, 1'b0, 1'b0),
            // size change in mid image, counters carry on
            size_row(16'd5, 16'd4),
            // longest match, two bytes back: overlapping copy across the ring end
            req_row(8'h10, 1'b0),
            req_row(8'h01, 1'b0),
            // shortest match from 0: finishes the image, last two dropped
            req_row(8'hff, 1'b0),
            req_row(8'hff, 1'b0),
            // restart with eight matches; first reads cleared ring at 0x800
            req_row(8'hff, 1'b1),
            req_row(8'hff, 1'b0),
            req_row(8'h7f, 1'b0),
            // match from 0xfff wraps its read to 0
            req_row(8'h0e, 1'b0),
            req_row(8'h00, 1'b0),
            // zero width: everything dropped
            size_row(16'd0, 16'd7),
            seen_row(8'hd2, 1'b1, 1'b0, 8'h00, 32'd0, 1'b0, 1'b0),
            seen_row(8'h00, 1'b0, 1'b0, 8'h00, 32'd0, 1'b0, 1'b0),
            seen_row(8'hff, 1'b0, 1'b0, 8'h00, 32'd0, 1'b0, 1'b0),
            // largest image: first pixel sits at the start of the last line
            size_row(16'd65535, 16'd65535),
            seen_row(8'h00, 1'b1, 1'b0, 8'h00, 32'd0, 1'b0, 1'b0),
            seen_row(8'hff, 1'b0, 1'b1, 8'h00, 32'd4294770690, 1'b1, 1'b0),
            req_row(8'h80, 1'b0)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if (dir_rows[i].kind == ROW_SIZE) begin
                quiesce();
                set_size(dir_rows[i].w, dir_rows[i].h);
            end else begin
                issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].has_px,
                      dir_rows[i].px);
            end
        end

        // random phases, each under its own image size
        for (p = 0; p < RAND_PHASES; p++) begin
            quiesce();
            case (p)
                1: begin
                    w = 16'd1;
                    h = 16'd1;
                end
                3: begin
                    w = 16'd65535;
                    h = 16'd65535;
                end
                5: begin
                    w = 16'd65535;
                    h = 16'($urandom_range(1, 3));
                end
                7: begin
                    w = 16'd1;
                    h = 16'd65535;
                end
                8: begin
                    // zero height
                    w = 16'($urandom_range(0, 3));
                    h = 16'd0;
                end
                default: begin
                    w = 16'($urandom_range(1, 12));
                    h = 16'($urandom_range(1, 10));
                end
            endcase
            set_size(w, h);
            no_idle    = ($urandom_range(0, 4) == 0);
            // now and then the image runs on under the new size
            keep_image = (p != 0) && ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // sender waits for every owed pixel, once for sure and now and then
                if ((p == 4 && k == PHASE_ITEMS / 2) || $urandom_range(0, 99) == 0) begin
                    quiesce();
                end
                rq = next_request(k == 0 && !keep_image);
                issue(rq, 1'b0, 1'b0, '0);
            end
        end

        quiesce();
        if (pixels_due.size() != 0) begin
            if (fail_count < 10) begin
                $display("%0d expected pixels never came out", pixels_due.size());
            end
            fail_count += pixels_due.size();
        end
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/lzid_pkg.sv
src/lzid_ring.sv
src/lzss_image_decoder.sv
verif/tb.sv
